>>> hdl/bipbuf_pkg.sv
// Package for the bipartite buffer index manager: request codes and defaults.
package bipbuf_pkg;

	typedef enum logic [1:0] {
		ACT_WRITE_ACQUIRE = 2'd0,
		ACT_WRITE_RELEASE = 2'd1,
		ACT_READ_ACQUIRE  = 2'd2,
		ACT_READ_RELEASE  = 2'd3
	} action_t;

	localparam int MAX_DEPTH_DEFAULT = 4096;
	localparam int SIZE_RESET        = 4096;

endpackage

>>> hdl/bipartite_buffer_index_manager.sv
// Bipartite buffer index manager: write, read and invalidate indexes with wrap flags.

// One item is accepted on any cycle with start high. busy is always low. The
// result of each item appears on the result ports after the input and result
// registers, for one cycle, marked by strobe. The receiver cannot stall.
// An input register and a result register sit around one short pass of
// compares and adds on the index registers. State updated by one item is
// seen by the next item, even when it follows in the very next cycle.
// Writing buffer_size (clamped to 1..MAX_DEPTH) also clears all indexes and
// both wrap flags. Do not write it while an item is still in flight.
// A release that would run past the buffer end returns error and leaves all
// state, wrap flags included, unchanged.
module bipartite_buffer_index_manager #(
	parameter int MAX_DEPTH = bipbuf_pkg::MAX_DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [$clog2(MAX_DEPTH+1)-1:0]     buffer_size,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         action,
	input  logic [$clog2(MAX_DEPTH+1)-1:0]     amount,
	output logic                               strobe,
	output logic                               granted,
	output logic [$clog2(MAX_DEPTH)-1:0]       offset,
	output logic [$clog2(MAX_DEPTH+1)-1:0]     available,
	output logic                               error
);
	import bipbuf_pkg::*;

	localparam int IDX_W    = $clog2(MAX_DEPTH);
	localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
	localparam int RST_SIZE = (SIZE_RESET > MAX_DEPTH) ? MAX_DEPTH : SIZE_RESET;

	// input register
	logic             valid_s1;
	action_t          action_s1;
	logic [CNT_W-1:0] amount_s1;

	// index state
	logic [CNT_W-1:0] size_q;
	logic [IDX_W-1:0] write_index_q;
	logic [IDX_W-1:0] read_index_q;
	logic [CNT_W-1:0] invalidate_index_q;
	logic             write_wrap_q;
	logic             read_wrap_q;

	// result register
	logic             strobe_q;
	logic             granted_q;
	logic [IDX_W-1:0] offset_q;
	logic [CNT_W-1:0] available_q;
	logic             error_q;

	logic [CNT_W-1:0] w_c, r_c;
	logic [CNT_W-1:0] free_c, lin_c, linfree_c;
	logic [CNT_W-1:0] wbase_c, ninv_c, wnew_c, rbase_c, rnew_c;
	logic [CNT_W:0]   wsum_c, rsum_c;
	logic [CNT_W-1:0] size_cfg_c;

	logic             granted_c, error_c;
	logic [IDX_W-1:0] offset_c;
	logic [CNT_W-1:0] avail_c;
	logic             set_wwrap_c, set_rwrap_c;
	logic             upd_w_c, upd_r_c;

	assign busy = 1'b0;

	always_comb begin
		if (buffer_size == '0) begin
			size_cfg_c = CNT_W'(1);
		end else if (buffer_size > CNT_W'(MAX_DEPTH)) begin
			size_cfg_c = CNT_W'(MAX_DEPTH);
		end else begin
			size_cfg_c = buffer_size;
		end
	end

	always_comb begin
		w_c = CNT_W'(write_index_q);
		r_c = CNT_W'(read_index_q);

		free_c    = (r_c > w_c) ? (r_c - w_c - CNT_W'(1)) : (size_q - (w_c - r_c) - CNT_W'(1));
		lin_c     = size_q - w_c;
		linfree_c = (free_c < lin_c) ? free_c : lin_c;

		// write release: a pending wrap restarts at zero and marks the old end
		wbase_c = write_wrap_q ? '0 : w_c;
		wsum_c  = (CNT_W+1)'(wbase_c) + (CNT_W+1)'(amount_s1);
		ninv_c  = write_wrap_q ? w_c : invalidate_index_q;
		if (wsum_c[CNT_W-1:0] > ninv_c) begin
			ninv_c = wsum_c[CNT_W-1:0];
		end
		wnew_c = (wsum_c[CNT_W-1:0] == size_q) ? '0 : wsum_c[CNT_W-1:0];

		rbase_c = read_wrap_q ? '0 : r_c;
		rsum_c  = (CNT_W+1)'(rbase_c) + (CNT_W+1)'(amount_s1);
		rnew_c  = (rsum_c[CNT_W-1:0] == size_q) ? '0 : rsum_c[CNT_W-1:0];

		granted_c   = 1'b0;
		offset_c    = '0;
		avail_c     = '0;
		error_c     = 1'b0;
		set_wwrap_c = 1'b0;
		set_rwrap_c = 1'b0;
		upd_w_c     = 1'b0;
		upd_r_c     = 1'b0;

		case (action_s1)
			ACT_WRITE_ACQUIRE: begin
				if (amount_s1 <= linfree_c) begin
					granted_c = 1'b1;
					offset_c  = write_index_q;
				end else if (amount_s1 <= free_c - linfree_c) begin
					granted_c   = 1'b1;
					set_wwrap_c = 1'b1;
				end
			end
			ACT_WRITE_RELEASE: begin
				if (wsum_c > (CNT_W+1)'(size_q)) begin
					error_c = 1'b1;
				end else begin
					upd_w_c = 1'b1;
				end
			end
			ACT_READ_ACQUIRE: begin
				if (r_c == w_c) begin
					granted_c = 1'b0;
				end else if (r_c < w_c) begin
					granted_c = 1'b1;
					offset_c  = read_index_q;
					avail_c   = w_c - r_c;
				end else if (r_c >= invalidate_index_q) begin
					// reader has hit the mark: wrap to the start
					granted_c   = 1'b1;
					set_rwrap_c = 1'b1;
					avail_c     = w_c;
				end else begin
					granted_c = 1'b1;
					offset_c  = read_index_q;
					avail_c   = invalidate_index_q - r_c;
				end
			end
			ACT_READ_RELEASE: begin
				if (rsum_c > (CNT_W+1)'(size_q)) begin
					error_c = 1'b1;
				end else begin
					upd_r_c = 1'b1;
				end
			end
			default: begin
				error_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1           <= 1'b0;
			strobe_q           <= 1'b0;
			size_q             <= CNT_W'(RST_SIZE);
			write_index_q      <= '0;
			read_index_q       <= '0;
			invalidate_index_q <= '0;
			write_wrap_q       <= 1'b0;
			read_wrap_q        <= 1'b0;
		end else begin
			valid_s1 <= start;
			strobe_q <= valid_s1;
			if (cfg_we) begin
				size_q             <= size_cfg_c;
				write_index_q      <= '0;
				read_index_q       <= '0;
				invalidate_index_q <= '0;
				write_wrap_q       <= 1'b0;
				read_wrap_q        <= 1'b0;
			end else if (valid_s1) begin
				if (set_wwrap_c) begin
					write_wrap_q <= 1'b1;
				end
				if (set_rwrap_c) begin
					read_wrap_q <= 1'b1;
				end
				if (upd_w_c) begin
					write_wrap_q       <= 1'b0;
					write_index_q      <= wnew_c[IDX_W-1:0];
					invalidate_index_q <= ninv_c;
				end
				if (upd_r_c) begin
					read_wrap_q  <= 1'b0;
					read_index_q <= rnew_c[IDX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			action_s1 <= action_t'(action);
			amount_s1 <= amount;
		end
		granted_q   <= granted_c;
		offset_q    <= offset_c;
		available_q <= avail_c;
		error_q     <= error_c;
	end

	assign strobe    = strobe_q;
	assign granted   = granted_q;
	assign offset    = offset_q;
	assign available = available_q;
	assign error     = error_q;

	a_write_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(write_index_q) < size_q)
		else $error("write index at or past buffer size");

	a_read_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(read_index_q) < size_q)
		else $error("read index at or past buffer size");

	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		invalidate_index_q <= size_q)
		else $error("invalidate mark past buffer size");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 strobe)
		else $error("item result not delivered two cycles after accept");

	a_error_not_granted: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && error) |-> !granted)
		else $error("release error reported together with a grant");

endmodule
